// ===== hw/rtl/diffusion_ftcs_grid_step_core_defines.svh =====
// assertion macros shared by the diffusion step core
`ifndef DIFFUSION_FTCS_GRID_STEP_CORE_DEFINES_SVH
`define DIFFUSION_FTCS_GRID_STEP_CORE_DEFINES_SVH
`ifndef SYNTH
`define DFG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DFG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFG_ASSERT(lbl, prop, msg)
`define DFG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/dfg_pkg.sv =====
// types and constants of the diffusion step core
package dfg_pkg;

    localparam int CELL_W   = 26;
    localparam int RADIUS_W = 20;
    localparam int DIFF_W   = 30;
    localparam int MB_W     = 19;
    localparam int PROD_W   = DIFF_W + MB_W;
    localparam int QBITS    = 21;
    localparam int CFG_W    = 16;
    localparam int K_W      = 15;

    localparam logic [CELL_W-1:0]   CELL_MAX     = '1;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX   = '1;
    localparam logic [CELL_W-1:0]   INITIAL_MASS = CELL_W'(1000 * 65536);
    localparam logic [K_W-1:0]      K_RESET      = K_W'(1638);
    localparam logic [CFG_W-1:0]    STEPS_RESET  = CFG_W'(1000);

    localparam logic CFG_DIFF_COEF = 1'b0;
    localparam logic CFG_MAX_STEPS = 1'b1;
    localparam logic FUNC_STEP     = 1'b0;
    localparam logic FUNC_READ     = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_Q,
        ST_ROW,
        ST_ROW_C,
        ST_RA,
        ST_RB,
        ST_MK,
        ST_MR,
        ST_ACC,
        ST_DIV,
        ST_DIV_WAIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/dfg_mul.sv =====
// shared registered signed multiplier
module dfg_mul (
    input  logic                               clk,
    input  logic signed [dfg_pkg::DIFF_W-1:0]  a,
    input  logic signed [dfg_pkg::MB_W-1:0]    b,
    output logic signed [dfg_pkg::PROD_W-1:0]  p
);
    import dfg_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    // product registered before any use
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/dfg_div.sv =====
// restoring divider for the weighted radius, one quotient bit per cycle
module dfg_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 38
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [NUM_W-1:0]                 num,
    input  logic [DEN_W-1:0]                 den,
    output logic [dfg_pkg::RADIUS_W-1:0]     quotient,
    output dfg_pkg::div_stat_t               stat
);
    import dfg_pkg::*;

    localparam int N_W   = NUM_W + 6;
    localparam int CNT_W = $clog2(QBITS + 1);

    logic [N_W-1:0]    nshift;
    logic [N_W-1:0]    hi;
    logic [DEN_W-1:0]  rem_reg;
    logic [QBITS-1:0]  low_reg;
    logic [QBITS-1:0]  q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              take;

    // scaled numerator and its part above the quotient bits
    assign nshift = {num, 6'b000000};
    assign hi     = nshift >> QBITS;
    assign trial  = {rem_reg, low_reg[QBITS-1]};
    assign take   = trial >= {1'b0, den};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0 || hi >= N_W'(den))
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(QBITS);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi[DEN_W-1:0];
            low_reg <= nshift[QBITS-1:0];
            if (den == '0)
                q_reg <= '0;
            else
                q_reg <= '1;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            low_reg <= {low_reg[QBITS-2:0], 1'b0};
            q_reg   <= {q_reg[QBITS-2:0], take};
        end
    end

    // saturate to the result width
    assign quotient  = q_reg[QBITS-1] ? RADIUS_MAX : q_reg[RADIUS_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/diffusion_ftcs_grid_step_core.sv =====
// top level of the explicit 2-D diffusion step core
// One step item sweeps every interior cell once, through the states ST_RA,
// ST_RB, ST_MK, ST_MR and ST_ACC for each cell, using a single shared
// multiplier (update product, then radius weight), and ends with a
// bit-serial radius division. A read item passes through ST_READ and
// ST_READ_Q; a step after the stop limit is answered straight from idle.
// After reset the grid memory is initialized by a pass of one entry a cycle
// over 2^(clog2(W)+clog2(H)) entries (4096 at 64 by 64) before the first item
// is taken. The result register must be emptied before a new item is accepted.
`include "diffusion_ftcs_grid_step_core_defines.svh"

module diffusion_ftcs_grid_step_core #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [dfg_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [6:0]                        cell_x,
    input  logic [6:0]                        cell_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [15:0]                       step_index,
    output logic [dfg_pkg::RADIUS_W-1:0]      mean_square_radius,
    output logic [dfg_pkg::CELL_W-1:0]        cell_value,
    output logic                              stopped_flag
);
    import dfg_pkg::*;

    localparam int XA   = $clog2(GRID_W);
    localparam int YA   = $clog2(GRID_H);
    localparam int AW   = XA + YA;
    localparam int XW   = $clog2(GRID_W + 1);
    localparam int YW   = $clog2(GRID_H + 1);
    localparam int DXW  = XW + 2;
    localparam int DYW  = YW + 2;
    localparam int D2W  = $clog2(GRID_W * GRID_W + GRID_H * GRID_H + 1);
    localparam int SW   = D2W + 2;
    localparam int TW   = CELL_W + $clog2(GRID_W * GRID_H);
    localparam int WW   = TW + D2W;
    localparam int NV_W = PROD_W - 15;
    localparam logic [AW-1:0] CENTER_ADDR =
        {YA'((GRID_H + 2) / 2 - 1), XA'((GRID_W + 2) / 2 - 1)};

    state_t state_reg, state_next;

    logic [CELL_W-1:0] grid_mem [2**AW];
    logic [CELL_W-1:0] prev_mem [2**XA];
    logic [CELL_W-1:0] grid_q, prev_q;
    logic [AW-1:0]     grid_rd_addr, grid_wr_addr;
    logic [CELL_W-1:0] grid_wdata;
    logic              grid_we, prev_we;

    logic [AW-1:0]     clr_cnt_reg;
    logic [K_W-1:0]    k_reg;
    logic [CFG_W-1:0]  max_steps_reg;
    logic [15:0]       step_cnt_reg;
    logic              halted_reg;

    logic [XW-1:0]     x_reg;
    logic [YW-1:0]     y_reg;
    logic signed [DXW-1:0] dx_reg;
    logic signed [DYW-1:0] dy_reg;
    logic [D2W-1:0]    dx2_reg, dy2_reg;
    logic [CELL_W-1:0] c_reg, left_reg, right_reg, up_reg;
    logic [WW-1:0]     weighted_reg;
    logic [TW-1:0]     total_reg;
    logic [6:0]        rx_reg, ry_reg;
    logic              rd_in_grid_reg;

    logic              out_valid_reg;
    logic [15:0]       out_step_reg;
    logic [RADIUS_W-1:0] out_radius_reg;
    logic [CELL_W-1:0] out_cell_reg;
    logic              out_stop_reg;

    logic              in_accept;
    logic signed [DIFF_W-1:0] diff, mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [NV_W-1:0]   nv;
    logic [CELL_W-1:0] down_val, new_val;
    logic [D2W-1:0]    r2;
    logic signed [SW-1:0] dx2_sum, dy2_sum;
    logic              div_start;
    logic [RADIUS_W-1:0] div_q;
    div_stat_t         div_stat;
    logic              last_x, last_y, more_steps;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign last_x    = x_reg == XW'(GRID_W);
    assign last_y    = y_reg == YW'(GRID_H);
    assign more_steps = ({1'b0, step_cnt_reg} + 17'd1) < {1'b0, max_steps_reg};

    // shared units
    dfg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    dfg_div #(
        .NUM_W (WW),
        .DEN_W (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (weighted_reg),
        .den      (total_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // stencil sum and cell update
    assign down_val = (y_reg < YW'(GRID_H)) ? grid_q : '0;
    assign diff = DIFF_W'(left_reg) + DIFF_W'(right_reg) + DIFF_W'(up_reg)
                + DIFF_W'(down_val) - DIFF_W'({c_reg, 2'b00});
    assign rnd  = prod + PROD_W'(32768);
    assign nv   = NV_W'(c_reg) + NV_W'(rnd >>> 16);
    assign r2   = D2W'(dx2_reg + dy2_reg);

    always_comb
    begin
        if (nv < 0)
            new_val = '0;
        else if (nv > NV_W'(CELL_MAX))
            new_val = CELL_MAX;
        else
            new_val = nv[CELL_W-1:0];
    end

    // squared offsets advance by 4*d + 4 as d steps by two
    assign dx2_sum = SW'(dx2_reg) + (SW'(dx_reg) <<< 2) + SW'(4);
    assign dy2_sum = SW'(dy2_reg) + (SW'(dy_reg) <<< 2) + SW'(4);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_accept)
                begin
                    if (func == FUNC_READ)
                        state_next = ST_READ;
                    else if (!halted_reg)
                        state_next = ST_ROW;
                end
            ST_READ:     state_next = ST_READ_Q;
            ST_READ_Q:   state_next = ST_IDLE;
            ST_ROW:      state_next = ST_ROW_C;
            ST_ROW_C:    state_next = ST_RA;
            ST_RA:       state_next = ST_RB;
            ST_RB:       state_next = ST_MK;
            ST_MK:       state_next = ST_MR;
            ST_MR:       state_next = ST_ACC;
            ST_ACC:
                if (!last_x)
                    state_next = ST_RA;
                else if (last_y)
                    state_next = ST_DIV;
                else
                    state_next = ST_ROW;
            ST_DIV:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_stat.done)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory ports and unit operands
    always_comb
    begin
        grid_rd_addr = '0;
        grid_wr_addr = {YA'(y_reg - YW'(1)), XA'(x_reg - XW'(1))};
        grid_wdata   = new_val;
        grid_we      = 1'b0;
        prev_we      = 1'b0;
        mul_a        = DIFF_W'(c_reg);
        mul_b        = MB_W'(r2);
        div_start    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                grid_we      = 1'b1;
                grid_wr_addr = clr_cnt_reg;
                grid_wdata   = (clr_cnt_reg == CENTER_ADDR) ? INITIAL_MASS : '0;
            end
            ST_READ:
                grid_rd_addr = {YA'(ry_reg - 7'd1), XA'(rx_reg - 7'd1)};
            ST_ROW:
                grid_rd_addr = {YA'(y_reg - YW'(1)), XA'(0)};
            ST_RA:
                grid_rd_addr = {YA'(y_reg - YW'(1)), XA'(x_reg)};
            ST_RB:
                grid_rd_addr = {YA'(y_reg), XA'(x_reg - XW'(1))};
            ST_MK:
            begin
                mul_a = diff;
                mul_b = MB_W'(k_reg);
            end
            ST_MR:
            begin
                grid_we = 1'b1;
                prev_we = 1'b1;
            end
            ST_DIV:
                div_start = 1'b1;
            default:
            begin
            end
        endcase
    end

    // grid and row memories
    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_wr_addr] <= grid_wdata;
        grid_q <= grid_mem[grid_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[XA'(x_reg - XW'(1))] <= c_reg;
        prev_q <= prev_mem[XA'(x_reg - XW'(1))];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= K_RESET;
            max_steps_reg <= STEPS_RESET;
            step_cnt_reg  <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cfg_we)
            begin
                if (cfg_index == CFG_DIFF_COEF)
                    k_reg <= cfg_wdata[K_W-1:0];
                else
                    max_steps_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_accept && func == FUNC_STEP && halted_reg)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_READ_Q)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_DIV_WAIT && div_stat.done)
            begin
                out_valid_reg <= 1'b1;
                if (more_steps)
                    step_cnt_reg <= step_cnt_reg + 16'd1;
                else
                    halted_reg <= 1'b1;
            end
        end
    end

    // sweep datapath and result beat
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                begin
                    rx_reg         <= cell_x;
                    ry_reg         <= cell_y;
                    rd_in_grid_reg <= (cell_x != 7'd0) && (int'(cell_x) <= GRID_W)
                                   && (cell_y != 7'd0) && (int'(cell_y) <= GRID_H);
                    y_reg          <= YW'(1);
                    dy_reg         <= DYW'(0) - DYW'(GRID_H);
                    dy2_reg        <= D2W'(GRID_H * GRID_H);
                    weighted_reg   <= '0;
                    total_reg      <= '0;
                    out_step_reg   <= step_cnt_reg;
                    out_radius_reg <= '0;
                    out_cell_reg   <= '0;
                    out_stop_reg   <= halted_reg;
                end
            ST_READ_Q:
                out_cell_reg <= rd_in_grid_reg ? grid_q : '0;
            ST_ROW_C:
            begin
                c_reg    <= grid_q;
                left_reg <= '0;
                x_reg    <= XW'(1);
                dx_reg   <= DXW'(0) - DXW'(GRID_W);
                dx2_reg  <= D2W'(GRID_W * GRID_W);
            end
            ST_RB:
            begin
                right_reg <= last_x ? '0 : grid_q;
                up_reg    <= (y_reg == YW'(1)) ? '0 : prev_q;
            end
            ST_ACC:
            begin
                weighted_reg <= weighted_reg + WW'($unsigned(prod));
                total_reg    <= total_reg + TW'(c_reg);
                left_reg     <= c_reg;
                c_reg        <= right_reg;
                x_reg        <= x_reg + XW'(1);
                dx_reg       <= dx_reg + DXW'(2);
                dx2_reg      <= D2W'(dx2_sum);
                if (last_x)
                begin
                    y_reg   <= y_reg + YW'(1);
                    dy_reg  <= dy_reg + DYW'(2);
                    dy2_reg <= D2W'(dy2_sum);
                end
            end
            ST_DIV_WAIT:
                if (div_stat.done)
                begin
                    out_radius_reg <= div_q;
                    out_stop_reg   <= !more_steps;
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid          = out_valid_reg;
    assign step_index         = out_step_reg;
    assign mean_square_radius = out_radius_reg;
    assign cell_value         = out_cell_reg;
    assign stopped_flag       = out_stop_reg;

    // checks
    `DFG_ASSERT(a_hold_while_result, out_valid_reg |-> in_stall, "item taken while result pending")
    `DFG_ASSERT(a_halted_counter, halted_reg |=> $stable(step_cnt_reg), "counter moved after stop")
    `DFG_ASSERT(a_div_done_wait, div_stat.done |-> state_reg == ST_DIV_WAIT, "divider done unexpected")
    `DFG_ASSERT(a_div_busy_done, !(div_stat.busy && div_stat.done), "divider busy and done")

endmodule
